>>> hdl/uniform_row_column_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Uniform row/column detector - assertion macros
// Shared property forms for the checker; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_ROW_COLUMN_DETECTOR_UNIT_DEFINES_SVH
`define UNIFORM_ROW_COLUMN_DETECTOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define URCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define URCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/urcd_pkg.sv
// ----------------------------------------------------------------------------
// Uniform row/column detector - package
// Request/report payload types, codes, defaults and pixel compare.
// ----------------------------------------------------------------------------
`default_nettype none

package urcd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_READ    = 1'b1;
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_COLUMN = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        row_end;
        logic        frame_end;
        logic [11:0] column_query;
    } t_req;

    typedef struct packed {
        logic        report_kind;
        logic [11:0] line_index;
        logic        keep;
        logic        frame_done;
        logic [12:0] living_rows;
        logic [12:0] living_columns;
        logic        nothing_to_crop;
    } t_rpt;

    // line store word: first-row pixel of a column plus its living flag
    typedef struct packed {
        logic        alive;
        logic [63:0] pixel;
    } t_col_entry;

    // pixel word is {alpha, blue, green, red}
    function automatic logic pix_equal(input logic [63:0] a, input logic [63:0] b,
                                       input logic alpha_en);
        logic [63:0] mask;
        logic        clear_pair;
        mask       = alpha_en ? {64{1'b1}} : {16'h0000, {48{1'b1}}};
        clear_pair = alpha_en && (a[63:48] == 16'h0000) && (b[63:48] == 16'h0000);
        return clear_pair || ((a & mask) == (b & mask));
    endfunction

endpackage

`default_nettype wire

>>> hdl/urcd_col_store.sv
// ----------------------------------------------------------------------------
// Uniform row/column detector - column line store
// Synchronous RAM with registered read and write-to-read forwarding for same-edge hits.
// ----------------------------------------------------------------------------
`default_nettype none

module urcd_col_store import urcd_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_col_entry    i_wr_data,
    output t_col_entry    o_rd_data
);

    t_col_entry r_mem [DEPTH];
    t_col_entry r_rd_data;
    t_col_entry r_fwd_data;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // read-first array: a write landing on the same edge as the read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

>>> hdl/uniform_row_column_detector_unit.sv
// ----------------------------------------------------------------------------
// Uniform row/column detector - top level
// Flags uniform rows and columns of a raster RGBA stream and reports counts.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                payload
//  request   in         i_req_valid / o_req_stall              i_req  (t_req)
//  report    out        o_rpt_valid / i_rpt_stall              o_rpt  (t_rpt)
//  config    in         i_cfg_we / i_cfg_wdata                 alpha_enabled
//
//  One request per cycle while the report queue has room; a report enters the
//  queue after its request's line-store read, then compare and write-back.
//  The line store is a single RAM with one read and one write per cycle.
//  Reset is synchronous; the line store needs no clearing pass.
//  A three-entry report queue decouples the sides; requests stall only
//  when that queue plus the request in flight could overfill it.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_row_column_detector_unit import urcd_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rpt_valid,
    input  logic i_rpt_stall,
    output t_rpt o_rpt,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int CW       = $clog2(MAX_WIDTH + 1);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int QCW      = (CW > 12) ? CW : 12;
    localparam int CNT_SPAN = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int KW       = (CNT_SPAN > 8191) ? $clog2(CNT_SPAN + 2) : 14;
    localparam int FIFO_DEPTH = 3;

    function automatic logic [12:0] cnt_out(input logic [KW-1:0] c);
        return (c > KW'(COUNT_MAX)) ? COUNT_MAX : c[12:0];
    endfunction

    function automatic logic [KW-1:0] cnt_inc(input logic [KW-1:0] c);
        return (c == {KW{1'b1}}) ? c : c + KW'(1);
    endfunction

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    // ---------------- configuration ----------------
    logic r_alpha_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_alpha_en <= i_cfg_wdata;
        end
    end

    // ---------------- accept stage ----------------
    logic          acc;
    logic          acc_rd;
    logic          acc_end;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    assign acc     = i_req_valid && !o_req_stall;
    assign acc_rd  = i_req.command == CMD_READ;
    assign acc_end = i_req.row_end || i_req.frame_end;
    assign rd_addr = acc_rd ? AW'(i_req.column_query) : r_col[AW-1:0];

    // position only depends on the request flags, so it advances at acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc && !acc_rd) begin
            if (!acc_end) begin
                if (r_col < CW'(MAX_WIDTH)) begin
                    r_col <= r_col + CW'(1);
                end
            end else begin
                r_col <= '0;
                if (i_req.frame_end) begin
                    r_row <= '0;
                end else if (r_row < RW'(MAX_HEIGHT - 1)) begin
                    r_row <= r_row + RW'(1);
                end
            end
        end
    end

    // ---------------- execute stage registers ----------------
    logic          r_s1_valid;
    logic          r_s1_cmd;
    logic [63:0]   r_s1_pix;
    logic          r_s1_row_end;
    logic          r_s1_frame_end;
    logic [CW-1:0] r_s1_x;
    logic [RW-1:0] r_s1_y;
    logic [11:0]   r_s1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cmd       <= i_req.command;
            r_s1_pix       <= {i_req.alpha, i_req.blue, i_req.green, i_req.red};
            r_s1_row_end   <= i_req.row_end;
            r_s1_frame_end <= i_req.frame_end;
            r_s1_x         <= r_col;
            r_s1_y         <= r_row;
            r_s1_q         <= i_req.column_query;
        end
    end

    // ---------------- line store ----------------
    logic       wr_en;
    t_col_entry wr_data;
    t_col_entry st_rd;

    urcd_col_store #(
        .DEPTH (MAX_WIDTH)
    ) u_col_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_x[AW-1:0]),
        .i_wr_data (wr_data),
        .o_rd_data (st_rd)
    );

    // ---------------- execute stage ----------------
    logic [63:0]   r_row_first;
    logic          r_row_alive;
    logic [CW-1:0] r_width;
    logic [KW-1:0] r_rows;
    logic [KW-1:0] r_cols;

    logic [63:0]   n_row_first;
    logic          n_row_alive;
    logic [CW-1:0] n_width;
    logic [KW-1:0] n_rows;
    logic [KW-1:0] n_cols;
    logic          push;
    t_rpt          push_rpt;
    logic          x_zero;
    logic          y_zero;
    logic          none_live;
    logic          all_live;

    always_comb begin
        n_row_first = r_row_first;
        n_row_alive = r_row_alive;
        n_width     = r_width;
        n_rows      = r_rows;
        n_cols      = r_cols;
        wr_en       = 1'b0;
        wr_data     = '{alive: 1'b0, pixel: r_s1_pix};
        push        = 1'b0;
        push_rpt    = '0;
        x_zero      = r_s1_x == '0;
        y_zero      = r_s1_y == '0;
        none_live   = 1'b0;
        all_live    = 1'b0;
        if (r_s1_valid) begin
            if (r_s1_cmd == CMD_READ) begin
                push                    = 1'b1;
                push_rpt.report_kind    = KIND_COLUMN;
                push_rpt.line_index     = r_s1_q;
                push_rpt.keep           = (QCW'(r_s1_q) < QCW'(r_width)) && st_rd.alive;
                push_rpt.living_rows    = cnt_out(r_rows);
                push_rpt.living_columns = cnt_out(r_cols);
            end else begin
                // first pixel of a frame restarts the counts
                if (x_zero && y_zero) begin
                    n_rows  = '0;
                    n_cols  = '0;
                    n_width = '0;
                end
                if (x_zero) begin
                    n_row_first = r_s1_pix;
                    n_row_alive = 1'b0;
                end else if (!pix_equal(r_row_first, r_s1_pix, r_alpha_en)) begin
                    n_row_alive = 1'b1;
                end
                if (r_s1_x < CW'(MAX_WIDTH)) begin
                    if (y_zero) begin
                        wr_en   = 1'b1;
                        n_width = r_s1_x + CW'(1);
                    end else if (r_s1_x < r_width && !st_rd.alive &&
                                 !pix_equal(st_rd.pixel, r_s1_pix, r_alpha_en)) begin
                        wr_en         = 1'b1;
                        wr_data.alive = 1'b1;
                        wr_data.pixel = st_rd.pixel;
                        n_cols        = cnt_inc(n_cols);
                    end
                end
                if (r_s1_row_end || r_s1_frame_end) begin
                    if (n_row_alive) begin
                        n_rows = cnt_inc(n_rows);
                    end
                    none_live = (n_rows == '0) || (n_cols == '0);
                    all_live  = (n_cols == KW'(n_width)) &&
                                (n_rows == KW'(r_s1_y) + KW'(1));
                    push                     = 1'b1;
                    push_rpt.report_kind     = KIND_ROW;
                    push_rpt.line_index      = 12'(r_s1_y);
                    push_rpt.keep            = n_row_alive;
                    push_rpt.frame_done      = r_s1_frame_end;
                    push_rpt.living_rows     = cnt_out(n_rows);
                    push_rpt.living_columns  = cnt_out(n_cols);
                    push_rpt.nothing_to_crop = r_s1_frame_end && (none_live || all_live);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_first <= n_row_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_alive <= 1'b0;
            r_width     <= '0;
            r_rows      <= '0;
            r_cols      <= '0;
        end else begin
            r_row_alive <= n_row_alive;
            r_width     <= n_width;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
        end
    end

    // ---------------- report queue ----------------
    t_rpt       r_fifo [FIFO_DEPTH];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_rpt_valid = r_cnt != 2'd0;
    assign o_rpt       = r_fifo[r_rp];
    assign pop         = o_rpt_valid && !i_rpt_stall;
    assign o_req_stall = ({1'b0, r_cnt} + {2'b00, r_s1_valid}) >= 3'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_rpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/urcd_checker.sv
// ----------------------------------------------------------------------------
// Uniform row/column detector - port checker
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uniform_row_column_detector_unit_defines.svh"

module urcd_checker import urcd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input t_req i_req,
    input logic o_rpt_valid,
    input logic i_rpt_stall,
    input t_rpt o_rpt,
    input logic i_cfg_we,
    input logic i_cfg_wdata
);

    logic req_acc;
    logic req_reports;
    logic cfg_seen;

    assign req_acc     = i_req_valid && !o_req_stall;
    assign req_reports = (i_req.command == CMD_READ) || i_req.row_end || i_req.frame_end;
    assign cfg_seen    = i_cfg_we || i_cfg_wdata;

    `URCD_ASSERT_NEXT(a_rpt_hold, o_rpt_valid && i_rpt_stall, o_rpt_valid && $stable(o_rpt), "report changed while stalled")

    // an empty report queue always has room for a request
    `URCD_ASSERT_NOW(a_empty_no_stall, !o_rpt_valid, !o_req_stall, "request stalled with empty report queue")

    // an accepted read, row end or frame end makes a report valid once it has passed the execute stage into the queue
    `URCD_ASSERT_NOW(a_req_to_rpt, req_acc && req_reports, ##2 o_rpt_valid, "request produced no report")

    `URCD_ASSERT_NOW(a_crop_flag, o_rpt_valid && o_rpt.nothing_to_crop && !cfg_seen, o_rpt.frame_done && o_rpt.report_kind == KIND_ROW, "crop flag outside frame end row report")

endmodule

bind uniform_row_column_detector_unit urcd_checker u_urcd_checker (.*);

`default_nettype wire

>>> verif/uniform_row_column_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// Uniform row/column detector - testbench
// Streams small RGBA frames and column reads with random gaps and report
// stalls, predicts every row/column report in a scoreboard and compares each
// accepted report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module uniform_row_column_detector_unit_tb import urcd_pkg::*; ();

    class crop_report_scoreboard;
        bit          alpha_en;
        logic [63:0] first_row_pix [DEF_MAX_WIDTH];
        bit          col_alive [DEF_MAX_WIDTH];
        logic [63:0] row_first_pix;
        bit          row_alive;
        int unsigned col_cnt;
        int unsigned row_cnt;
        int unsigned live_rows;
        int unsigned live_cols;
        int unsigned width_cnt;
        t_rpt        expected_reports [$];
        int          errors;

        function new();
            row_first_pix = '0;
        endfunction

        // pixel word is {alpha, blue, green, red}
        function bit pixels_match(logic [63:0] a, logic [63:0] b);
            if (alpha_en && a[63:48] == 16'h0 && b[63:48] == 16'h0)
                return 1'b1;
            return alpha_en ? (a == b) : (a[47:0] == b[47:0]);
        endfunction

        function logic [12:0] clamp_count(int unsigned c);
            return (c > COUNT_MAX) ? COUNT_MAX : c[12:0];
        endfunction

        function void note_request(t_req r);
            logic [63:0] pix;
            int unsigned x;
            int unsigned y;
            t_rpt        e;
            bit          none_live;
            bit          all_live;
            e = '0;
            if (r.command == CMD_READ) begin
                e.report_kind    = KIND_COLUMN;
                e.line_index     = r.column_query;
                e.keep           = (r.column_query < width_cnt) ? col_alive[r.column_query] : 1'b0;
                e.living_rows    = clamp_count(live_rows);
                e.living_columns = clamp_count(live_cols);
                expected_reports.push_back(e);
                return;
            end

            pix = {r.alpha, r.blue, r.green, r.red};
            x   = col_cnt;
            y   = row_cnt;

            if (x == 0) begin
                if (y == 0) begin
                    live_rows = 0;
                    live_cols = 0;
                    width_cnt = 0;
                end
                row_first_pix = pix;
                row_alive     = 1'b0;
            end else if (!pixels_match(row_first_pix, pix)) begin
                row_alive = 1'b1;
            end

            // pixels past the first row's width only count for the row check
            if (x < DEF_MAX_WIDTH) begin
                if (y == 0) begin
                    first_row_pix[x] = pix;
                    col_alive[x]     = 1'b0;
                    width_cnt        = x + 1;
                end else if (x < width_cnt && !col_alive[x] &&
                             !pixels_match(first_row_pix[x], pix)) begin
                    col_alive[x] = 1'b1;
                    live_cols++;
                end
            end

            if (!r.row_end && !r.frame_end) begin
                if (col_cnt < DEF_MAX_WIDTH)
                    col_cnt++;
                return;
            end

            if (row_alive)
                live_rows++;
            e.report_kind    = KIND_ROW;
            e.line_index     = 12'(y);
            e.keep           = row_alive;
            e.frame_done     = r.frame_end;
            e.living_rows    = clamp_count(live_rows);
            e.living_columns = clamp_count(live_cols);
            if (r.frame_end) begin
                none_live         = (live_rows == 0) || (live_cols == 0);
                all_live          = (live_cols == width_cnt) && (live_rows == y + 1);
                e.nothing_to_crop = none_live || all_live;
            end
            expected_reports.push_back(e);

            col_cnt = 0;
            if (r.frame_end)
                row_cnt = 0;
            else if (row_cnt < DEF_MAX_HEIGHT - 1)
                row_cnt++;
        endfunction

        task report_mismatch(string what, logic [15:0] got_v, logic [15:0] exp_v);
            if (errors < 40)
                $display("%0t ns: mismatch on %s: got %0h, expected %0h",
                         $time, what, got_v, exp_v);
            errors++;
        endtask

        task check_report(t_rpt got);
            t_rpt e;
            if (expected_reports.size() == 0) begin
                report_mismatch("report with none pending, line", got.line_index, 16'h0);
                return;
            end
            e = expected_reports.pop_front();
            if (got.report_kind !== e.report_kind)
                report_mismatch("report_kind", got.report_kind, e.report_kind);
            if (got.line_index !== e.line_index)
                report_mismatch("line_index", got.line_index, e.line_index);
            if (got.keep !== e.keep)
                report_mismatch("keep", got.keep, e.keep);
            if (got.frame_done !== e.frame_done)
                report_mismatch("frame_done", got.frame_done, e.frame_done);
            if (got.living_rows !== e.living_rows)
                report_mismatch("living_rows", got.living_rows, e.living_rows);
            if (got.living_columns !== e.living_columns)
                report_mismatch("living_columns", got.living_columns, e.living_columns);
            if (got.nothing_to_crop !== e.nothing_to_crop)
                report_mismatch("nothing_to_crop", got.nothing_to_crop, e.nothing_to_crop);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    t_req req;
    logic rpt_valid;
    logic rpt_stall;
    t_rpt rpt;
    logic cfg_we;
    logic cfg_wdata;

    crop_report_scoreboard sb = new();
    t_req stim_queue [$];
    int   stall_pct    = 0;
    int   holdoff_left = 0;

    uniform_row_column_detector_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rpt_valid (rpt_valid),
        .i_rpt_stall (rpt_stall),
        .o_rpt       (rpt),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // report side: random stalls, or a long hold-off when asked for
    initial begin
        rpt_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff_left > 0) begin
                rpt_stall <= 1'b1;
                holdoff_left--;
            end else begin
                rpt_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rpt_valid && !rpt_stall)
                sb.check_report(rpt);
        end
    end

    function automatic logic [63:0] random_pixel();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void push_pixel(logic [63:0] pix, bit row_end, bit frame_end);
        t_req r;
        r.command                      = CMD_PIXEL;
        {r.alpha, r.blue, r.green, r.red} = pix;
        r.row_end                      = row_end;
        r.frame_end                    = frame_end;
        r.column_query                 = 12'($urandom_range(4095));
        stim_queue.push_back(r);
    endfunction

    // pixel and marker bits of a read request are don't-care noise
    function automatic void push_read(logic [11:0] column);
        t_req r;
        r.command                      = CMD_READ;
        {r.alpha, r.blue, r.green, r.red} = random_pixel();
        r.row_end                      = 1'($urandom_range(1));
        r.frame_end                    = 1'($urandom_range(1));
        r.column_query                 = column;
        stim_queue.push_back(r);
    endfunction

    // small frame built from a few related colors so that uniform rows and
    // columns actually occur; odd row lengths and reads mixed in
    function automatic void queue_random_frame();
        logic [63:0] colors [5];
        logic [63:0] first_row [$];
        logic [63:0] pix;
        int          width;
        int          height;
        int          len;
        int          style;
        int          pick;
        bit          last_row;
        width  = $urandom_range(1, 6);
        height = $urandom_range(1, 6);
        colors[0] = random_pixel();
        if ($urandom_range(3) == 0)
            colors[0][63:48] = 16'h0;
        pix       = random_pixel();
        colors[1] = {pix[63:48], colors[0][47:0]};     // alpha differs only
        colors[2] = {16'h0, pix[47:0]};                // transparent
        pix       = random_pixel();
        colors[3] = {16'h0, pix[47:0]};                // transparent, other color
        colors[4] = colors[0] ^ (64'h1 << $urandom_range(63));
        for (int y = 0; y < height; y++) begin
            last_row = (y == height - 1);
            len      = width;
            if (y > 0 && $urandom_range(7) == 0)
                len = $urandom_range(1, width + 2);
            style = $urandom_range(7);
            pick  = $urandom_range(4);
            for (int x = 0; x < len; x++) begin
                if ($urandom_range(11) == 0)
                    push_read(($urandom_range(3) == 0) ? 12'($urandom_range(4095)) :
                                                         12'($urandom_range(width + 1)));
                if (y > 0 && style < 3 && x < width)
                    pix = ($urandom_range(7) == 0) ? colors[$urandom_range(4)] : first_row[x];
                else if (style < 5)
                    pix = colors[pick];
                else if (style < 7)
                    pix = colors[$urandom_range(4)];
                else
                    pix = random_pixel();
                if (y == 0)
                    first_row.push_back(pix);
                if (x == len - 1)
                    push_pixel(pix, last_row ? ($urandom_range(3) != 0) : 1'b1, last_row);
                else
                    push_pixel(pix, 1'b0, 1'b0);
            end
        end
        if ($urandom_range(2) == 0)
            push_read(12'($urandom_range(width + 1)));
    endfunction

    task automatic wait_drained();
        @(posedge clk);
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        // pixels without a report may still be in the pipeline
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(bit alpha, int send_idle, int rpt_idle, int hold);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= alpha;
        @(posedge clk);
        cfg_we      <= 1'b0;
        sb.alpha_en  = alpha;
        stall_pct    = rpt_idle;
        holdoff_left = hold;
        while (stim_queue.size() != 0) begin
            if (send_idle > 0 && $urandom_range(99) < send_idle) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end else begin
                req       <= stim_queue.pop_front();
                req_valid <= 1'b1;
                @(posedge clk);
                while (req_stall)
                    @(posedge clk);
            end
        end
        req_valid <= 1'b0;
    endtask

    initial begin
        int          send_idle_pct [4];
        int          rpt_idle_pct [4];
        send_idle_pct = '{0, 58, 0, 16};
        rpt_idle_pct  = '{0, 0, 58, 16};
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // opaque compare: channel extremes, alpha-only difference ignored,
        // frame end without row end, overlong last row, single-pixel frame
        push_read(12'd0);
        push_pixel(64'h0, 1'b0, 1'b0);
        push_pixel(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_pixel(64'h0, 1'b1, 1'b0);
        push_pixel(64'h0, 1'b0, 1'b0);
        push_pixel(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_pixel(64'hFFFF_0000_0000_0000, 1'b1, 1'b0);
        push_pixel(64'h0, 1'b0, 1'b0);
        push_pixel(64'h0, 1'b0, 1'b0);
        push_pixel(64'h0, 1'b0, 1'b0);
        push_pixel(64'h0, 1'b0, 1'b1);
        push_read(12'd1);
        push_read(12'd3);
        push_read(12'hFFF);
        push_pixel(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        run_phase(1'b0, 0, 0, 0);

        // alpha compare: transparent pixels of different color are equal
        push_pixel(64'h0000_0000_0000_0005, 1'b0, 1'b0);
        push_pixel(64'h0000_0000_0000_0009, 1'b1, 1'b0);
        push_pixel(64'h0000_0000_0000_0009, 1'b0, 1'b0);
        push_pixel(64'h0001_0000_0000_0009, 1'b1, 1'b1);
        push_read(12'd0);
        push_read(12'd1);
        run_phase(1'b1, 0, 0, 0);

        for (int p = 0; p < 8; p++) begin
            while (stim_queue.size() < 72)
                queue_random_frame();
            run_phase(1'((p + p / 4) % 2), send_idle_pct[p % 4], rpt_idle_pct[p % 4],
                      (p % 4 == 0) ? 60 : 0);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/urcd_pkg.sv
hdl/urcd_col_store.sv
hdl/uniform_row_column_detector_unit.sv
hdl/urcd_checker.sv
verif/uniform_row_column_detector_unit_tb.sv
